// ===== src/aac_pkg.sv =====
package aac_pkg;

   // field widths
   localparam int ACCEL_W    = 16;
   localparam int MAG_W      = 16;
   localparam int ONE_G_W    = 15;
   localparam int THRESH_W   = 16;
   localparam int ACT_W      = 2;
   localparam int SQ_W       = 32;

   // stream payloads, padded to whole bytes
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ONE_G = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REST  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WALK  = 2'd2;

   localparam logic [ONE_G_W-1:0]  ONE_G_RST = 15'd8192;
   localparam logic [THRESH_W-1:0] REST_RST  = 16'd819;
   localparam logic [THRESH_W-1:0] WALK_RST  = 16'd4096;

   // activity classes
   localparam logic [ACT_W-1:0] ACT_REST = 2'd0;
   localparam logic [ACT_W-1:0] ACT_WALK = 2'd1;
   localparam logic [ACT_W-1:0] ACT_RUN  = 2'd2;

   // averaging window
   localparam int WINDOW_LEN_DEF = 10;
   localparam int MOTION_MAX     = 65535;

   // square root unit
   localparam int ROOT_STEPS = 16;
   localparam int ROOT_CNT_W = 4;
   localparam logic [ROOT_CNT_W-1:0] ROOT_CNT_LAST = 4'(ROOT_STEPS - 1);
   localparam logic [SQ_W-1:0] ROOT_BIT_INIT = 32'h4000_0000;

   typedef struct packed {
      logic busy;
      logic done;
   } root_stat_type;

endpackage

// ===== src/aac_ram.sv =====
module aac_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH = 10,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/aac_isqrt.sv =====
module aac_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [aac_pkg::SQ_W-1:0]   operand,
   output logic [aac_pkg::MAG_W-1:0]  root,
   output aac_pkg::root_stat_type     stat
);
   import aac_pkg::*;

   logic [SQ_W-1:0]       rem_ff, rem_in;
   logic [SQ_W-1:0]       root_ff, root_in;
   logic [SQ_W-1:0]       bit_ff, bit_in;
   logic [ROOT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [SQ_W-1:0]       trial;

   // one result bit per cycle, restoring method
   always_comb begin
      trial   = root_ff + bit_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = operand;
         root_in = '0;
         bit_in  = ROOT_BIT_INIT;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ROOT_CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign root      = root_ff[MAG_W-1:0];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== src/accel_activity_classifier.sv =====
// Activity classifier for a three-axis accelerometer.
// req_ channel: one request carries a raw sample (x, y, z, signed counts).
// rsp_ channel: one response per request, the window mean of net motion
//   (|sqrt(x^2+y^2+z^2) - one g|) and an activity class (rest/walk/run).
// csr_ port: write-only registers, index 0 one-g count, 1 rest threshold,
//   2 walk threshold; a write lands on the clock edge where csr_we is high.
// Timing: a request passes from acceptance through squaring on one shared
//   multiplier, the bit-per-cycle square root, and the window update and
//   divide, then its response is loaded into the output register. The block
//   takes a new request while the previous response still waits.
// The motion window sits in a small RAM; its old entry is read when the
//   request arrives and the new one written back in the update cycle.
// Reset: synchronous, active high. Control registers return to their defaults, the
//   window reads as all zeros (per-entry valid bits) and the sum is cleared,
//   so early means include zeros. No clearing pass is needed.
// Stall: if rsp_tready is low, the response holds and the next result waits
//   in the divide stage, so req_tready stays low until the output frees up.
module accel_activity_classifier #(
   parameter int WINDOW_LEN = aac_pkg::WINDOW_LEN_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
   input  logic [aac_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // activity [1:0], average_motion [17:2], zero fill [23:18]
   output logic [aac_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_we,
   input  logic [aac_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [aac_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import aac_pkg::*;

   localparam int ADDR_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int SUM_W   = $clog2(WINDOW_LEN * MOTION_MAX + 1);
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SUM_W) / WINDOW_LEN);
   localparam logic [SUM_W-1:0]   WIN_SUM = SUM_W'(WINDOW_LEN);
   localparam logic [SUM_W:0]     WIN_TWICE = (SUM_W + 1)'(2 * WINDOW_LEN);
   localparam logic [ADDR_W-1:0]  SLOT_LAST = ADDR_W'(WINDOW_LEN - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SQUARE = 3'd1;
   localparam logic [2:0] ST_ROOT   = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_DIVM   = 3'd4;
   localparam logic [2:0] ST_DIVC   = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [ACCEL_W-1:0]    ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic [1:0]            sq_cnt_ff, sq_cnt_in;
   logic [SQ_W-1:0]       acc_ff, acc_in;
   logic [ADDR_W-1:0]     slot_ff, slot_in;
   logic [WINDOW_LEN-1:0] valid_ff, valid_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [MAG_W-1:0]      q_ff, q_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [ONE_G_W-1:0]    one_g_ff, one_g_in;
   logic [THRESH_W-1:0]   rest_ff, rest_in;
   logic [THRESH_W-1:0]   walk_ff, walk_in;

   logic                  req_accept;
   logic                  out_free;
   logic [ACCEL_W-1:0]    sq_op;
   logic [SQ_W-1:0]       sq_prod;
   logic [SQ_W-1:0]       sq_total;
   logic                  root_start;
   root_stat_type         root_stat;
   logic [MAG_W-1:0]      mag;
   logic [MAG_W-1:0]      rd_data;
   logic [MAG_W-1:0]      old_motion;
   logic [MAG_W-1:0]      net_motion;
   logic                  ram_wr;
   logic [PROD_W-1:0]     recip_prod;
   logic [SUM_W-1:0]      q_times_w;
   logic [SUM_W-1:0]      div_rem;
   logic [MAG_W-1:0]      mean;
   logic [ACT_W-1:0]      act;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // shared squaring multiplier
   always_comb begin
      case (sq_cnt_ff)
         2'd0:    sq_op = ax_ff;
         2'd1:    sq_op = ay_ff;
         default: sq_op = az_ff;
      endcase
   end
   assign sq_prod    = SQ_W'(sq_op) * SQ_W'(sq_op);
   assign sq_total   = acc_ff + sq_prod;
   assign root_start = (state_ff == ST_SQUARE) && (sq_cnt_ff == 2'd2);

   aac_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (root_start),
      .operand (sq_total),
      .root    (mag),
      .stat    (root_stat)
   );

   // net motion and window update
   assign net_motion = ({1'b0, mag} >= {2'b0, one_g_ff}) ? mag - MAG_W'(one_g_ff)
                                                          : MAG_W'(one_g_ff) - mag;
   assign old_motion = valid_ff[slot_ff] ? rd_data : '0;
   assign ram_wr     = (state_ff == ST_UPDATE);

   aac_ram #(
      .DATA_W (MAG_W),
      .DEPTH  (WINDOW_LEN)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (slot_ff),
      .wr_data (net_motion),
      .rd_en   (req_accept),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   // divide by window length: reciprocal estimate, then one correction
   assign recip_prod = PROD_W'(sum_ff) * PROD_W'(RECIP);
   assign q_times_w  = SUM_W'(q_ff) * WIN_SUM;
   assign div_rem    = sum_ff - q_times_w;
   assign mean       = (div_rem >= WIN_SUM) ? q_ff + 1'b1 : q_ff;

   // classification
   always_comb begin
      if (mean < rest_ff) begin
         act = ACT_REST;
      end else if (mean < walk_ff) begin
         act = ACT_WALK;
      end else begin
         act = ACT_RUN;
      end
   end

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      az_in        = az_ff;
      sq_cnt_in    = sq_cnt_ff;
      acc_in       = acc_ff;
      slot_in      = slot_ff;
      valid_in     = valid_ff;
      sum_in       = sum_ff;
      q_in         = q_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               ax_in     = req_tdata[15] ? 16'(~req_tdata[15:0] + 1'b1) : req_tdata[15:0];
               ay_in     = req_tdata[31] ? 16'(~req_tdata[31:16] + 1'b1) : req_tdata[31:16];
               az_in     = req_tdata[47] ? 16'(~req_tdata[47:32] + 1'b1) : req_tdata[47:32];
               sq_cnt_in = '0;
               acc_in    = '0;
               state_in  = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            acc_in    = sq_total;
            sq_cnt_in = sq_cnt_ff + 1'b1;
            if (root_start) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_stat.done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            sum_in            = sum_ff - SUM_W'(old_motion) + SUM_W'(net_motion);
            valid_in[slot_ff] = 1'b1;
            slot_in           = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
            state_in          = ST_DIVM;
         end
         ST_DIVM: begin
            q_in     = recip_prod[SUM_W +: MAG_W];
            state_in = ST_DIVC;
         end
         ST_DIVC: begin
            if (out_free) begin
               rsp_data_in  = {(RSP_DATA_W - MAG_W - ACT_W)'(0), mean, act};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration registers
   always_comb begin
      one_g_in = one_g_ff;
      rest_in  = rest_ff;
      walk_in  = walk_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ONE_G: one_g_in = csr_wdata[ONE_G_W-1:0];
            CSR_REST:  rest_in  = csr_wdata[THRESH_W-1:0];
            CSR_WALK:  walk_in  = csr_wdata[THRESH_W-1:0];
            default:   ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sq_cnt_ff    <= '0;
         slot_ff      <= '0;
         valid_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         one_g_ff     <= ONE_G_RST;
         rest_ff      <= REST_RST;
         walk_ff      <= WALK_RST;
      end else begin
         state_ff     <= state_in;
         sq_cnt_ff    <= sq_cnt_in;
         slot_ff      <= slot_in;
         valid_ff     <= valid_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         one_g_ff     <= one_g_in;
         rest_ff      <= rest_in;
         walk_ff      <= walk_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      az_ff       <= az_in;
      acc_ff      <= acc_in;
      q_ff        <= q_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   // write slot never leaves the window
   assert property (@(posedge clock) disable iff (reset) slot_ff <= SLOT_LAST)
      else $error("write slot out of window");

   // square root must be running or finishing while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> (root_stat.busy || root_stat.done))
      else $error("waiting on an idle square root unit");

   // the slot just written reads back as valid
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |=> valid_ff[$past(slot_ff)])
      else $error("window entry not marked valid after write");

   // reciprocal estimate is at most one below the true quotient
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVC) |-> ({1'b0, div_rem} < WIN_TWICE))
      else $error("divide correction out of range");

   // a response only appears from the divide stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DIVC))
      else $error("response raised outside the divide stage");
`endif

endmodule
